// ===== rtl/core/bbc_pkg.sv =====
// Package for the clipped 11x11 box blur: constants, codes, transfer types and sequencer states.
package bbc_pkg;

    // Default geometry of the filter and of the row store.
    localparam int RADIUS_DEF    = 5;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    // Widths fixed by the register fields.
    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_BITS   = 13;
    localparam int ROW_BITS   = 12;

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Input item commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // One input item.
    typedef struct packed {
        logic       command;
        logic [7:0] pixel_value;
    } pix_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] blurred_pixel;
        logic       last_of_frame;
    } res_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TAIL,
        ST_DIVST,
        ST_DIV
    } bbc_state_t;

endpackage

// ===== rtl/core/bbc_history.sv =====
// Row history store: single write port, single read port with registered read data.
module bbc_history #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bbc_divider.sv =====
// Restoring divider: one quotient bit per cycle, quotient held until the next start.
module bbc_divider #(
    parameter int NW = 16,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);

    localparam int KW = $clog2(NW + 1);

    logic [DW:0]   rem_reg,  rem_next;
    logic [NW-1:0] quo_reg,  quo_next;
    logic [DW-1:0] dvs_reg,  dvs_next;
    logic [KW-1:0] step_reg, step_next;
    logic          busy_reg, busy_next;
    logic [DW+1:0] trial;

    // One shift and trial subtraction a cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            step_next = KW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, dvs_reg})
            begin
                rem_next = (DW+1)'(trial - {2'b00, dvs_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == KW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/box_blur_11x11_clipped.sv =====
// Top level of the clipped box blur: frame counters, window read sequencer and result register.
//
//  Channel | Direction | Handshake          | Payload
//  pix     | in        | pix_valid/pix_stall| bbc_pkg::pix_item_t
//  res     | out       | res_valid/res_stall| bbc_pkg::res_item_t
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// An item that gives no result leaves the sequencer idle. An item that gives a result holds
// pix_stall high through ST_READ, ST_TAIL, ST_DIVST and ST_DIV: the N pixels inside the clipped
// window (up to 121) are read from the single read port of the row history,
// one pixel a cycle, and the mean comes from a one-bit-a-cycle divider.
// Reset clears all frame counters; the row history holds no reset value.
// A waiting result sits in the output register while the next item is transferred.
module box_blur_11x11_clipped #(
    parameter int RADIUS    = bbc_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH = bbc_pkg::MAX_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pix_valid,
    output logic                       pix_stall,
    input  bbc_pkg::pix_item_t         pix,
    output logic                       res_valid,
    input  logic                       res_stall,
    output bbc_pkg::res_item_t         res,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bbc_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int SLOTS = 3 * RADIUS + 1;
    localparam int SLOTW = $clog2(SLOTS);
    localparam int DEPTH = SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CNTW  = WW + 14;
    localparam int CW    = $clog2((2 * RADIUS + 1) * (2 * RADIUS + 1) + 1);
    localparam int SW    = 8 + CW;
    localparam int RW    = bbc_pkg::ROW_BITS;

    // Configuration and derived frame constants.
    logic [bbc_pkg::CFG_W_BITS-1:0] cfg_w_reg;
    logic [bbc_pkg::CFG_H_BITS-1:0] cfg_h_reg;
    logic [WW-1:0]   w_eff;
    logic [12:0]     h_eff;
    logic [CNTW-1:0] total, lag;
    logic [COLW-1:0] wm1;
    logic [RW-1:0]   hm1;

    // Frame counters.
    logic [CNTW-1:0]  items_reg,    items_next;
    logic [COLW-1:0]  in_col_reg,   in_col_next;
    logic [SLOTW-1:0] in_slot_reg,  in_slot_next;
    logic [COLW-1:0]  out_col_reg,  out_col_next;
    logic [RW-1:0]    out_row_reg,  out_row_next;
    logic [SLOTW-1:0] out_slot_reg, out_slot_next;

    // Window walk.
    bbc_pkg::bbc_state_t state_reg, state_next;
    logic [COLW-1:0]  rx_reg, rx_next, x0_reg, x0_next, xe_reg, xe_next;
    logic [RW-1:0]    ry_reg, ry_next, ye_reg, ye_next;
    logic [SLOTW-1:0] rslot_reg, rslot_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             last_reg, last_next;

    // Result register.
    logic                res_valid_reg, res_valid_next;
    bbc_pkg::res_item_t  res_reg, res_next;

    // Memory and divider connections.
    logic          wr_en, rd_en, div_start, div_busy;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;
    logic [SW-1:0] quotient;

    // Window bounds of the next result.
    logic             accept, pending, drain, emit, is_last, restart;
    logic [RW-1:0]    y0, ye_w;
    logic [COLW-1:0]  x0, xe_w;
    logic [SLOTW-1:0] back, s0;
    logic [RW:0]      y_hi;
    logic [COLW:0]    x_hi;

    // Clamp the configured sizes.
    always_comb
    begin
        if (cfg_w_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(cfg_w_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(cfg_w_reg);
        end
        if (cfg_h_reg == '0)
        begin
            h_eff = 13'd1;
        end
        else if (32'(cfg_h_reg) > bbc_pkg::MAX_HEIGHT)
        begin
            h_eff = 13'(bbc_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = cfg_h_reg;
        end
    end

    // Frame constants follow the registers without delay.
    assign total = CNTW'(w_eff) * CNTW'(h_eff);
    assign lag   = CNTW'(w_eff) * CNTW'(RADIUS) + CNTW'(RADIUS);
    assign wm1   = COLW'(w_eff - 1'b1);
    assign hm1   = RW'(h_eff - 1'b1);

    // Window bounds from the current output position.
    always_comb
    begin
        y_hi = {1'b0, out_row_reg} + (RW+1)'(RADIUS);
        x_hi = {1'b0, out_col_reg} + (COLW+1)'(RADIUS);
        if (32'(out_row_reg) >= RADIUS)
        begin
            y0   = out_row_reg - RW'(RADIUS);
            back = SLOTW'(RADIUS);
        end
        else
        begin
            y0   = '0;
            back = SLOTW'(out_row_reg);
        end
        x0   = (32'(out_col_reg) >= RADIUS) ? out_col_reg - COLW'(RADIUS) : '0;
        ye_w = (y_hi > {1'b0, hm1}) ? hm1 : y_hi[RW-1:0];
        xe_w = (x_hi > {1'b0, wm1}) ? wm1 : x_hi[COLW-1:0];
        if (out_slot_reg >= back)
        begin
            s0 = out_slot_reg - back;
        end
        else
        begin
            s0 = SLOTW'(32'(out_slot_reg) + SLOTS - 32'(back));
        end
    end

    assign accept  = pix_valid && !pix_stall;
    assign pending = items_reg < total;
    assign drain   = (pix.command == bbc_pkg::CMD_DRAIN);
    assign emit    = accept && !(pending && drain) && (items_reg >= lag);
    assign is_last = (out_row_reg == hm1) && (out_col_reg == wm1);
    assign restart = cfg_we || (emit && is_last);

    assign wr_en   = accept && pending && !drain;
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign rd_en   = (state_reg == bbc_pkg::ST_READ);
    assign rd_addr = AW'(rslot_reg) * AW'(MAX_WIDTH) + AW'(rx_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bbc_pkg::ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = bbc_pkg::ST_READ;
                end
            end
            bbc_pkg::ST_READ:
            begin
                if (rx_reg == xe_reg && ry_reg == ye_reg)
                begin
                    state_next = bbc_pkg::ST_TAIL;
                end
            end
            bbc_pkg::ST_TAIL:
            begin
                state_next = bbc_pkg::ST_DIVST;
            end
            bbc_pkg::ST_DIVST:
            begin
                state_next = bbc_pkg::ST_DIV;
            end
            bbc_pkg::ST_DIV:
            begin
                if (!div_busy && (!res_valid_reg || !res_stall))
                begin
                    state_next = bbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pix_stall = (state_reg != bbc_pkg::ST_IDLE);
        div_start = (state_reg == bbc_pkg::ST_DIVST);
    end

    // Counters, window walk and result register.
    always_comb
    begin
        items_next     = items_reg;
        in_col_next    = in_col_reg;
        in_slot_next   = in_slot_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_slot_next  = out_slot_reg;
        rx_next        = rx_reg;
        x0_next        = x0_reg;
        xe_next        = xe_reg;
        ry_next        = ry_reg;
        ye_next        = ye_reg;
        rslot_next     = rslot_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        rd_pend_next   = 1'b0;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        // Item transfer: count the item; a pixel is stored only while the frame is pending.
        if (accept && !(pending && drain))
        begin
            items_next = items_reg + 1'b1;
            if (pending)
            begin
                if (in_col_reg == wm1)
                begin
                    in_col_next  = '0;
                    in_slot_next = (32'(in_slot_reg) == SLOTS - 1) ? '0 : in_slot_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
        end

        // A result is due: capture its window and move the output position on.
        if (emit)
        begin
            rx_next    = x0;
            x0_next    = x0;
            xe_next    = xe_w;
            ry_next    = y0;
            ye_next    = ye_w;
            rslot_next = s0;
            sum_next   = '0;
            cnt_next   = '0;
            last_next  = is_last;
            if (out_col_reg == wm1)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_slot_next = (32'(out_slot_reg) == SLOTS - 1) ? '0 : out_slot_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end

        // Frame restart.
        if (restart)
        begin
            items_next    = '0;
            in_col_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end

        // Walk the window one pixel a cycle.
        if (state_reg == bbc_pkg::ST_READ)
        begin
            rd_pend_next = 1'b1;
            cnt_next     = cnt_reg + 1'b1;
            if (rx_reg == xe_reg)
            begin
                rx_next    = x0_reg;
                ry_next    = ry_reg + 1'b1;
                rslot_next = (32'(rslot_reg) == SLOTS - 1) ? '0 : rslot_reg + 1'b1;
            end
            else
            begin
                rx_next = rx_reg + 1'b1;
            end
        end

        // Accumulate read data.
        if (rd_pend_reg)
        begin
            sum_next = sum_reg + SW'(rd_data);
        end

        // Result register: drain on transfer, load when the quotient is ready.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (state_reg == bbc_pkg::ST_DIV && !div_busy && (!res_valid_reg || !res_stall))
        begin
            res_valid_next         = 1'b1;
            res_next.blurred_pixel = quotient[7:0];
            res_next.last_of_frame = last_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbc_pkg::ST_IDLE;
            cfg_w_reg     <= bbc_pkg::FRAME_WIDTH_RST;
            cfg_h_reg     <= bbc_pkg::FRAME_HEIGHT_RST;
            items_reg     <= '0;
            in_col_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == bbc_pkg::CFG_FRAME_WIDTH)
            begin
                cfg_w_reg <= cfg_data[bbc_pkg::CFG_W_BITS-1:0];
            end
            if (cfg_we && cfg_index == bbc_pkg::CFG_FRAME_HEIGHT)
            begin
                cfg_h_reg <= cfg_data;
            end
            items_reg     <= items_next;
            in_col_reg    <= in_col_next;
            in_slot_reg   <= in_slot_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            rd_pend_reg   <= rd_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rx_reg    <= rx_next;
        x0_reg    <= x0_next;
        xe_reg    <= xe_next;
        ry_reg    <= ry_next;
        ye_reg    <= ye_next;
        rslot_reg <= rslot_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
    end

    bbc_history #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_history (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pix.pixel_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbc_divider #(
        .NW (SW),
        .DW (CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
